// ===== sv/pfrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrgb_pkg
// Shared types and constants of the pixel format to RGB888 converter.
// ----------------------------------------------------------------------------
package pfrgb_pkg;

  localparam int PIX_W  = 64;
  localparam int CH_W   = 8;
  localparam int FMT_W  = 3;
  localparam int HALF_W = 16;
  localparam int FLT_W  = 32;

  typedef logic [FMT_W-1:0] fmt_t;

  // Source format codes; unlisted codes behave as RGBA8.
  localparam fmt_t FMT_RGBA8   = 3'd0;
  localparam fmt_t FMT_BGRA8   = 3'd1;
  localparam fmt_t FMT_R8      = 3'd2;
  localparam fmt_t FMT_RGBA16F = 3'd3;
  localparam fmt_t FMT_R32F    = 3'd4;
  localparam fmt_t FMT_R16F    = 3'd5;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // Advance enables of the three pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } adv_t;

endpackage

// ===== sv/pfrgb_pix_if.sv =====
// ----------------------------------------------------------------------------
// pfrgb_pix_if
// Input channel: one source pixel word per item.
// ----------------------------------------------------------------------------
interface pfrgb_pix_if;
  import pfrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

// ===== sv/pfrgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// pfrgb_rgb_if
// Result channel: one RGB888 pixel per item.
// ----------------------------------------------------------------------------
interface pfrgb_rgb_if;
  import pfrgb_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/pfrgb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pfrgb_cfg_if
// Configuration write channel for the source format register.
// ----------------------------------------------------------------------------
interface pfrgb_cfg_if;
  import pfrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [FMT_W-1:0] source_format;

  modport source (output valid, output source_format, input ready);
  modport sink (input valid, input source_format, output ready);
endinterface

// ===== sv/pfrgb_half_conv.sv =====
// ----------------------------------------------------------------------------
// pfrgb_half_conv
// Two-stage half float to byte converter: clamp to [0,1], scale by 255,
// truncate.
// ----------------------------------------------------------------------------
module pfrgb_half_conv (
  input  logic                       clk,
  input  pfrgb_pkg::adv_t            adv,
  input  logic [pfrgb_pkg::HALF_W-1:0] half_in,
  output logic [pfrgb_pkg::CH_W-1:0] byte_out
);
  import pfrgb_pkg::*;

  logic       sign;
  logic [4:0] ex;
  logic [9:0] man;

  logic [18:0] prod_r, prod_nxt;
  logic [4:0]  sh_r, sh_nxt;
  logic        zero_r, zero_nxt;
  logic        sat_r, sat_nxt;
  logic [CH_W-1:0] byte_r, byte_nxt;

  assign sign = half_in[15];
  assign ex   = half_in[14:10];
  assign man  = half_in[9:0];

  // Stage 1: scaled significand and classification.
  always_comb begin
    prod_nxt = 19'({1'b1, man}) * 19'd255;
    sh_nxt   = 5'd25 - ex;
    zero_nxt = 1'b0;
    sat_nxt  = 1'b0;
    if (ex == 5'd0) begin
      zero_nxt = 1'b1;
    end else if (sign) begin
      zero_nxt = 1'b1;
    end else if (ex >= 5'd15) begin
      // Covers the all-ones exponent as well: positive values saturate.
      sat_nxt = 1'b1;
    end
  end

  // Stage 2: align the exact product down to the integer byte.
  always_comb begin
    if (zero_r) begin
      byte_nxt = '0;
    end else if (sat_r) begin
      byte_nxt = CH_MAX;
    end else begin
      byte_nxt = CH_W'(prod_r >> sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      prod_r <= prod_nxt;
      sh_r   <= sh_nxt;
      zero_r <= zero_nxt;
      sat_r  <= sat_nxt;
    end
    if (adv.en2) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

// ===== sv/pfrgb_float_conv.sv =====
// ----------------------------------------------------------------------------
// pfrgb_float_conv
// Single float to byte converter: scale by 255 with round to nearest even
// at 24 bits, then truncate. Two register stages, final shift combinational.
// ----------------------------------------------------------------------------
module pfrgb_float_conv (
  input  logic                        clk,
  input  pfrgb_pkg::adv_t             adv,
  input  logic [pfrgb_pkg::FLT_W-1:0] flt_in,
  output logic [pfrgb_pkg::CH_W-1:0]  byte_out
);
  import pfrgb_pkg::*;

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;

  logic [31:0] s_r, s_nxt;
  logic [7:0]  ex_r;
  logic        zero1_r, zero1_nxt;
  logic        sat1_r, sat1_nxt;

  logic [3:0]  d;
  logic [24:0] rt;
  logic [7:0]  rem, half;
  logic        rnd;
  logic [7:0]  sh;

  logic [24:0] r_r, r_nxt;
  logic [5:0]  sh_r;
  logic        zero2_r, zero2_nxt;
  logic        sat2_r;

  assign sign = flt_in[31];
  assign ex   = flt_in[30:23];
  assign man  = flt_in[22:0];

  // Stage 1: product of the significand and 255, classification.
  always_comb begin
    s_nxt     = 32'({1'b1, man}) * 32'd255;
    zero1_nxt = 1'b0;
    sat1_nxt  = 1'b0;
    if (ex == 8'hFF) begin
      if (man != '0 || sign) begin
        zero1_nxt = 1'b1;
      end else begin
        sat1_nxt = 1'b1;
      end
    end else if (sign || ex == 8'd0) begin
      zero1_nxt = 1'b1;
    end else if (ex >= 8'd127) begin
      sat1_nxt = 1'b1;
    end
  end

  // Stage 2: round the product to a 24-bit significand, ties to even.
  always_comb begin
    if (s_r[31]) begin
      d = 4'd8;
    end else if (s_r[30]) begin
      d = 4'd7;
    end else begin
      d = 4'd6;
    end
    rt        = 25'(s_r >> d);
    rem       = s_r[7:0] & ((8'd1 << d) - 8'd1);
    half      = 8'd1 << (d - 4'd1);
    rnd       = (rem > half) || (rem == half && rt[0]);
    r_nxt     = rt + 25'(rnd);
    sh        = 8'd150 - ex_r - 8'(d);
    zero2_nxt = zero1_r || (!sat1_r && sh >= 8'd40);
  end

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      s_r     <= s_nxt;
      ex_r    <= ex;
      zero1_r <= zero1_nxt;
      sat1_r  <= sat1_nxt;
    end
    if (adv.en2) begin
      r_r     <= r_nxt;
      sh_r    <= sh[5:0];
      zero2_r <= zero2_nxt;
      sat2_r  <= sat1_r;
    end
  end

  // The stage 3 register in the top level captures this shift.
  always_comb begin
    if (zero2_r) begin
      byte_out = '0;
    end else if (sat2_r) begin
      byte_out = CH_MAX;
    end else begin
      byte_out = CH_W'(r_r >> sh_r);
    end
  end

endmodule

// ===== sv/pixel_format_to_rgb888_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_format_to_rgb888_unit
// Converts one source pixel word to RGB888 under the source format register.
// ----------------------------------------------------------------------------
// Items pass the stage 1, 2 and 3 registers. Throughput: one item per cycle
// while the output is ready; the three-stage pipeline with its output
// register stalls stage by stage, so bubbles are filled under backpressure.
// Reset clears all stage valid bits and sets the source format to RGBA8.
module pixel_format_to_rgb888_unit (
  input  logic        clk,
  input  logic        rst_n,
  pfrgb_pix_if.sink   in_pix,
  pfrgb_rgb_if.source out_rgb,
  pfrgb_cfg_if.sink   cfg_wr
);
  import pfrgb_pkg::*;

  fmt_t fmt_cfg_r;

  logic v1_r, v2_r, v3_r;
  adv_t adv;

  fmt_t fmt1_r, fmt2_r;
  logic [3*CH_W-1:0] bytes1_r, bytes2_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;

  logic [CH_W-1:0] h_red, h_green, h_blue, f_byte;

  assign adv.en3 = !v3_r || out_rgb.ready;
  assign adv.en2 = !v2_r || adv.en3;
  assign adv.en1 = !v1_r || adv.en2;

  assign in_pix.ready = adv.en1;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cfg_r <= FMT_RGBA8;
    end else if (cfg_wr.valid) begin
      fmt_cfg_r <= cfg_wr.source_format;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv.en1) v1_r <= in_pix.valid;
      if (adv.en2) v2_r <= v1_r;
      if (adv.en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      fmt1_r   <= fmt_cfg_r;
      bytes1_r <= in_pix.pixel_word[3*CH_W-1:0];
    end
    if (adv.en2) begin
      fmt2_r   <= fmt1_r;
      bytes2_r <= bytes1_r;
    end
    if (adv.en3) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  pfrgb_half_conv u_half_red (
    .clk      (clk),
    .adv      (adv),
    .half_in  (in_pix.pixel_word[HALF_W-1:0]),
    .byte_out (h_red)
  );

  pfrgb_half_conv u_half_green (
    .clk      (clk),
    .adv      (adv),
    .half_in  (in_pix.pixel_word[2*HALF_W-1:HALF_W]),
    .byte_out (h_green)
  );

  pfrgb_half_conv u_half_blue (
    .clk      (clk),
    .adv      (adv),
    .half_in  (in_pix.pixel_word[3*HALF_W-1:2*HALF_W]),
    .byte_out (h_blue)
  );

  pfrgb_float_conv u_float (
    .clk      (clk),
    .adv      (adv),
    .flt_in   (in_pix.pixel_word[FLT_W-1:0]),
    .byte_out (f_byte)
  );

  // Stage 3: pick the channel sources for the format.
  always_comb begin
    unique case (fmt2_r)
      FMT_BGRA8: begin
        red_nxt   = bytes2_r[3*CH_W-1:2*CH_W];
        green_nxt = bytes2_r[2*CH_W-1:CH_W];
        blue_nxt  = bytes2_r[CH_W-1:0];
      end
      FMT_R8: begin
        red_nxt   = bytes2_r[CH_W-1:0];
        green_nxt = bytes2_r[CH_W-1:0];
        blue_nxt  = bytes2_r[CH_W-1:0];
      end
      FMT_RGBA16F: begin
        red_nxt   = h_red;
        green_nxt = h_green;
        blue_nxt  = h_blue;
      end
      FMT_R32F: begin
        red_nxt   = f_byte;
        green_nxt = f_byte;
        blue_nxt  = f_byte;
      end
      FMT_R16F: begin
        red_nxt   = h_red;
        green_nxt = h_red;
        blue_nxt  = h_red;
      end
      default: begin
        red_nxt   = bytes2_r[CH_W-1:0];
        green_nxt = bytes2_r[2*CH_W-1:CH_W];
        blue_nxt  = bytes2_r[3*CH_W-1:2*CH_W];
      end
    endcase
  end

  assign out_rgb.valid = v3_r;
  assign out_rgb.red   = red_r;
  assign out_rgb.green = green_r;
  assign out_rgb.blue  = blue_r;

  // A full pipeline with a stalled output must hold off new items.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_rgb.ready) |-> !in_pix.ready)
    else $error("input accepted while pipeline is full and stalled");

  // An accepted item always occupies stage 1 in the next cycle.
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> v1_r)
    else $error("accepted item lost at stage 1");

  // Single-channel formats give the same byte on all three outputs.
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (adv.en3 && v2_r && (fmt2_r == FMT_R8 || fmt2_r == FMT_R32F || fmt2_r == FMT_R16F))
    |=> (out_rgb.red == out_rgb.green && out_rgb.green == out_rgb.blue))
    else $error("single-channel format gave unequal channels");

endmodule

// ===== sim/pixel_format_to_rgb888_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgb888_unit_test
// Self-checking bench for the RGB888 pixel converter. A directed table covers
// every source format and the special cases of each. Random pixels follow,
// shaped toward the interesting float ranges, with the format register
// rewritten between phases. Both handshakes are stalled at random.
// ----------------------------------------------------------------------------
module pixel_format_to_rgb888_unit_test;
  import pfrgb_pkg::*;

  localparam int   HALF_PERIOD  = 6;
  localparam int   RESET_CYCLES = 12;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   PHASE_ITEMS  = 145;
  localparam int   PHASES       = 10;
  localparam int   IDLE_PCT     = 21;
  localparam logic TYPED        = 1'b1;
  localparam logic PREDICTED    = 1'b0;

  // Codes without a name in the package; both must act as RGBA8.
  localparam fmt_t FMT_SPARE6 = 3'd6;
  localparam fmt_t FMT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb888_t;

  typedef struct packed {
    fmt_t             fmt;
    logic [PIX_W-1:0] word;
    logic             typed;
    rgb888_t          want;
  } pattern_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam pattern_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{FMT_RGBA8,   64'hFFEE_DDCC_4433_2211, TYPED,     '{8'h11, 8'h22, 8'h33}},
    '{FMT_RGBA8,   64'hFFFF_FFFF_FFFF_FFFF, TYPED,     '{8'hFF, 8'hFF, 8'hFF}},
    '{FMT_RGBA8,   64'h0000_0000_0000_0000, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_BGRA8,   64'h5555_AAAA_00A1_B2C3, TYPED,     '{8'hA1, 8'hB2, 8'hC3}},
    '{FMT_BGRA8,   64'hFFFF_FFFF_FFFF_FFFF, TYPED,     '{8'hFF, 8'hFF, 8'hFF}},
    '{FMT_R8,      64'hFFFF_FFFF_FFFF_FF5A, TYPED,     '{8'h5A, 8'h5A, 8'h5A}},
    // One, zero and minus one, with the unused top half set.
    '{FMT_RGBA16F, 64'hFFFF_BC00_0000_3C00, TYPED,     '{8'hFF, 8'h00, 8'h00}},
    // Plus infinity, minus infinity and a positive NaN pattern.
    '{FMT_RGBA16F, 64'h0000_7E00_FC00_7C00, TYPED,     '{8'hFF, 8'h00, 8'hFF}},
    '{FMT_RGBA16F, 64'h0000_3800_8001_03FF, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_RGBA16F, 64'h0000_C000_7BFF_3BFF, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_RGBA16F, 64'h0000_4000_3555_0400, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'hFFFF_FFFF_3F80_0000, TYPED,     '{8'hFF, 8'hFF, 8'hFF}},
    '{FMT_R32F,    64'h0000_0000_7F80_0000, TYPED,     '{8'hFF, 8'hFF, 8'hFF}},
    '{FMT_R32F,    64'h0000_0000_7FC0_0000, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_FFFF_FFFF, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_8000_0000, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_3F00_0000, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_3F7F_FFFF, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_0000_0001, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_R32F,    64'h0000_0000_C000_0000, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_R16F,    64'hFFFF_FFFF_FFFF_3C00, TYPED,     '{8'hFF, 8'hFF, 8'hFF}},
    '{FMT_R16F,    64'h0000_0000_0000_3A00, PREDICTED, '{8'h00, 8'h00, 8'h00}},
    '{FMT_R16F,    64'h0000_0000_0000_FC00, TYPED,     '{8'h00, 8'h00, 8'h00}},
    '{FMT_SPARE6,  64'h0000_0000_0012_3456, TYPED,     '{8'h56, 8'h34, 8'h12}},
    '{FMT_SPARE7,  64'hFFFF_FFFF_FF12_3456, TYPED,     '{8'h56, 8'h34, 8'h12}}
  };

  localparam fmt_t PHASE_FMT [8] = '{FMT_R32F, FMT_RGBA16F, FMT_BGRA8, FMT_SPARE7,
                                      FMT_R16F, FMT_R8, FMT_RGBA8, FMT_SPARE6};

  logic clk = 1'b0;
  logic rst_n;

  pfrgb_pix_if pix ();
  pfrgb_rgb_if rgb ();
  pfrgb_cfg_if cfg ();

  pixel_format_to_rgb888_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_rgb (rgb),
    .cfg_wr  (cfg)
  );

  always #HALF_PERIOD clk = ~clk;

  fmt_t    cur_fmt = FMT_RGBA8;
  rgb888_t pending_rgb [$];
  rgb888_t oldest;
  int      mismatches   = 0;
  int      idle_cycles  = 0;
  bit      steady       = 1'b0;
  bit      hold_request = 1'b0;
  bit      hold_done    = 1'b0;

  function automatic logic [CH_W-1:0] half_to_channel(input logic [HALF_W-1:0] h);
    logic [4:0]  ex;
    logic [31:0] prod;
    ex = h[14:10];
    if (ex == 5'd0) return '0;
    if (ex == 5'h1F) return h[15] ? '0 : CH_MAX;
    if (h[15]) return '0;
    if (ex >= 5'd15) return CH_MAX;
    // The product is exact: 1.m times 255, scaled by the exponent.
    prod = (32'd1024 + 32'(h[9:0])) * 32'd255;
    return CH_W'(prod >> (25 - int'(ex)));
  endfunction

  function automatic logic [CH_W-1:0] single_to_channel(input logic [FLT_W-1:0] f);
    logic [7:0]  ex;
    logic [63:0] prod, sig, rest, halfway;
    int          drop, sh;
    ex = f[30:23];
    if (ex == 8'hFF) return (f[22:0] != 0 || f[31]) ? '0 : CH_MAX;
    if (f[31] || ex == 8'd0) return '0;
    if (ex >= 8'd127) return CH_MAX;
    prod = ((64'd1 << 23) | 64'(f[22:0])) * 64'd255;
    if (prod < (64'd1 << 30)) drop = 6;
    else if (prod < (64'd1 << 31)) drop = 7;
    else drop = 8;
    // Round the product back to a 24-bit significand, ties to even.
    sig     = prod >> drop;
    rest    = prod & ((64'd1 << drop) - 64'd1);
    halfway = 64'd1 << (drop - 1);
    if (rest > halfway || (rest == halfway && sig[0])) sig = sig + 64'd1;
    sh = 150 - int'(ex) - drop;
    if (sh >= 40) return '0;
    return CH_W'(sig >> sh);
  endfunction

  function automatic rgb888_t convert_pixel(input fmt_t fmt, input logic [PIX_W-1:0] w);
    rgb888_t px;
    logic [CH_W-1:0] mono;
    case (fmt)
      FMT_BGRA8: px = '{w[23:16], w[15:8], w[7:0]};
      FMT_R8:    px = '{w[7:0], w[7:0], w[7:0]};
      FMT_RGBA16F: begin
        px = '{half_to_channel(w[15:0]), half_to_channel(w[31:16]),
               half_to_channel(w[47:32])};
      end
      FMT_R32F: begin
        mono = single_to_channel(w[31:0]);
        px   = '{mono, mono, mono};
      end
      FMT_R16F: begin
        mono = half_to_channel(w[15:0]);
        px   = '{mono, mono, mono};
      end
      default:   px = '{w[7:0], w[15:8], w[23:16]};
    endcase
    return px;
  endfunction

  // Most halves land near [0,1]; some are specials, some fully random.
  function automatic logic [HALF_W-1:0] random_half();
    logic [HALF_W-1:0] h;
    h = HALF_W'($urandom);
    case ($urandom_range(7))
      0: ;
      1: h[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
      default: begin
        h[15]    = ($urandom_range(7) == 0);
        h[14:10] = 5'($urandom_range(15, 5));
      end
    endcase
    return h;
  endfunction

  function automatic logic [FLT_W-1:0] random_single();
    logic [FLT_W-1:0] f;
    f = $urandom;
    case ($urandom_range(7))
      0: ;
      1: f[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: begin
        f[31]    = ($urandom_range(7) == 0);
        f[30:23] = 8'($urandom_range(127, 110));
      end
    endcase
    return f;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel(input fmt_t fmt);
    logic [PIX_W-1:0] w;
    w = {$urandom, $urandom};
    case (fmt)
      FMT_RGBA16F: begin
        w[15:0]  = random_half();
        w[31:16] = random_half();
        w[47:32] = random_half();
      end
      FMT_R16F: w[15:0] = random_half();
      FMT_R32F: w[31:0] = random_single();
      default: ;
    endcase
    return w;
  endfunction

  task automatic offer_pixel(input logic [PIX_W-1:0] word, input rgb888_t want);
    pix.valid      <= 1'b1;
    pix.pixel_word <= word;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pending_rgb.push_back(want);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // The register is only rewritten once the pipeline has drained.
  task automatic write_format(input fmt_t f);
    pix.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.source_format <= f;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_fmt = f;
  endtask

  task automatic compare_channel(input string label, input logic [CH_W-1:0] want_v,
                                 input logic [CH_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, label, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && rgb.valid && rgb.ready) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %02h %02h %02h",
                 $time, rgb.red, rgb.green, rgb.blue);
        mismatches++;
      end else begin
        oldest = pending_rgb.pop_front();
        compare_channel("red", oldest.red, rgb.red);
        compare_channel("green", oldest.green, rgb.green);
        compare_channel("blue", oldest.blue, rgb.blue);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, one long hold-off so the pipeline backs up.
  initial begin
    rgb.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        rgb.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        rgb.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rgb.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int               i, p, k;
    fmt_t             f;
    rgb888_t          want;
    logic [PIX_W-1:0] word;

    rst_n             <= 1'b0;
    pix.valid         <= 1'b0;
    pix.pixel_word    <= '0;
    cfg.valid         <= 1'b0;
    cfg.source_format <= FMT_RGBA8;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the reset value of the format register.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].fmt != cur_fmt) write_format(DIRECTED[i].fmt);
      want = DIRECTED[i].typed ? DIRECTED[i].want
                               : convert_pixel(cur_fmt, DIRECTED[i].word);
      offer_pixel(DIRECTED[i].word, want);
    end

    for (p = 0; p < PHASES; p++) begin
      f = (p < 8) ? PHASE_FMT[p] : fmt_t'($urandom_range(7));
      if (f != cur_fmt) write_format(f);
      steady = (p == 6);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 40) hold_request = 1'b1;
        word = random_pixel(cur_fmt);
        offer_pixel(word, convert_pixel(cur_fmt, word));
      end
    end
    steady    = 1'b0;
    pix.valid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pfrgb_pkg.sv
sv/pfrgb_pix_if.sv
sv/pfrgb_rgb_if.sv
sv/pfrgb_cfg_if.sv
sv/pfrgb_half_conv.sv
sv/pfrgb_float_conv.sv
sv/pixel_format_to_rgb888_unit.sv
sim/pixel_format_to_rgb888_unit_test.sv
